// File: rtl/smis_pkg.sv
// ----------------------------------------------------------------------------
// smis_pkg
// Shared constants, opcode codes and controller/datapath signal groups for
// the stack machine instruction step core.
// ----------------------------------------------------------------------------
package smis_pkg;

  localparam int WORD_BITS       = 16;
  localparam int MEM_WORDS_DEF   = 4096;
  localparam int STACK_DEPTH_DEF = 256;

  // instruction kinds
  localparam logic [4:0] K_POP   = 5'd0;
  localparam logic [4:0] K_PUSH  = 5'd1;
  localparam logic [4:0] K_STORE = 5'd2;
  localparam logic [4:0] K_LOAD  = 5'd3;
  localparam logic [4:0] K_PUSHS = 5'd4;
  localparam logic [4:0] K_CALL  = 5'd5;
  localparam logic [4:0] K_RET   = 5'd6;
  localparam logic [4:0] K_RETZ  = 5'd7;
  localparam logic [4:0] K_RETNZ = 5'd8;
  localparam logic [4:0] K_JMP   = 5'd9;
  localparam logic [4:0] K_JPC   = 5'd10;
  localparam logic [4:0] K_WRITE = 5'd11;
  localparam logic [4:0] K_READ  = 5'd12;
  localparam logic [4:0] K_GETC  = 5'd13;
  localparam logic [4:0] K_PUTC  = 5'd14;
  localparam logic [4:0] K_RND   = 5'd15;
  localparam logic [4:0] K_DUP   = 5'd16;
  localparam logic [4:0] K_MSWAP = 5'd17;
  localparam logic [4:0] K_ALU   = 5'd18;
  localparam logic [4:0] K_HALT  = 5'd19;

  // alu subcodes
  localparam logic [3:0] A_EQ  = 4'h0;
  localparam logic [3:0] A_NE  = 4'h1;
  localparam logic [3:0] A_GT  = 4'h2;
  localparam logic [3:0] A_GE  = 4'h3;
  localparam logic [3:0] A_LT  = 4'h4;
  localparam logic [3:0] A_LE  = 4'h5;
  localparam logic [3:0] A_AND = 4'h6;
  localparam logic [3:0] A_OR  = 4'h7;
  localparam logic [3:0] A_XOR = 4'h8;
  localparam logic [3:0] A_NOT = 4'h9;
  localparam logic [3:0] A_NEG = 4'ha;
  localparam logic [3:0] A_ADD = 4'hb;
  localparam logic [3:0] A_SUB = 4'hc;
  localparam logic [3:0] A_MUL = 4'hd;
  localparam logic [3:0] A_DIV = 4'he;
  localparam logic [3:0] A_MOD = 4'hf;

  // error codes
  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_OPC  = 3'd1;
  localparam logic [2:0] E_DIV  = 3'd2;
  localparam logic [2:0] E_STK  = 3'd3;
  localparam logic [2:0] E_ADR  = 3'd4;
  localparam logic [2:0] E_ALU  = 3'd5;

  // output kinds
  localparam logic [1:0] O_NONE = 2'd0;
  localparam logic [1:0] O_NUM  = 2'd1;
  localparam logic [1:0] O_CHR  = 2'd2;

  typedef struct packed {
    logic clr;
    logic accept;
    logic rd;
    logic ex1;
    logic div_go;
    logic wb;
    logic wb2;
    logic top;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_div;
    logic div_done;
    logic need_wb2;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/smis_if.sv
// ----------------------------------------------------------------------------
// smis_in_if / smis_out_if
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface smis_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  instr_kind;
  logic signed [15:0] operand;
  logic signed [15:0] supplied_value;

  modport source (output valid, instr_kind, operand, supplied_value, input ready);
  modport sink   (input valid, instr_kind, operand, supplied_value, output ready);
endinterface

interface smis_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [1:0]  out_kind;
  logic signed [15:0] out_value;
  logic        halted;
  logic signed [15:0] top_value;
  logic [2:0]  error_code;

  modport source (output valid, next_pc, out_kind, out_value, halted, top_value, error_code,
                  input ready);
  modport sink   (input valid, next_pc, out_kind, out_value, halted, top_value, error_code,
                  output ready);
endinterface

// File: rtl/smis_div.sv
// ----------------------------------------------------------------------------
// smis_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smis_div #(
  parameter int DW = smis_pkg::WORD_BITS + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] d_i,
  output logic          done_o,
  output logic [DW-1:0] q_o,
  output logic [DW-1:0] r_o
);

  localparam int CNTW = $clog2(DW);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   q_q, r_q, d_q;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {r_q, q_q[DW-1]};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= a_i;
      r_q <= '0;
      d_q <= d_i;
    end else if (busy_q) begin
      q_q <= {q_q[DW-2:0], fits};
      r_q <= fits ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign r_o    = r_q;

endmodule

// File: rtl/smis_ctrl.sv
// ----------------------------------------------------------------------------
// smis_ctrl
// Instruction sequencer: memory clearing, read, execute, divide, writeback.
// ----------------------------------------------------------------------------
module smis_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  smis_pkg::sts_t    sts_i,
  output smis_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EX1  = 4'd3;
  localparam logic [3:0] S_EX2  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_WB2  = 4'd7;
  localparam logic [3:0] S_TOP  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EX1;
      end
      S_EX1: begin
        cmd_o.ex1 = 1'b1;
        state_d   = S_EX2;
      end
      S_EX2: begin
        if (sts_i.need_div) begin
          cmd_o.div_go = 1'b1;
          state_d      = S_DIV;
        end else begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = sts_i.need_wb2 ? S_WB2 : S_TOP;
      end
      S_WB2: begin
        cmd_o.wb2 = 1'b1;
        state_d   = S_TOP;
      end
      S_TOP: begin
        cmd_o.top = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/smis_dp.sv
// ----------------------------------------------------------------------------
// smis_dp
// Datapath: pc, stack and data memories, checks, alu, divider, result register.
// ----------------------------------------------------------------------------
module smis_dp #(
  parameter int MEM_WORDS   = smis_pkg::MEM_WORDS_DEF,
  parameter int STACK_DEPTH = smis_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smis_pkg::cmd_t     cmd_i,
  output smis_pkg::sts_t     sts_o,
  input  logic [4:0]         instr_kind_i,
  input  logic [15:0]        operand_i,
  input  logic [15:0]        supplied_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        next_pc_o,
  output logic [1:0]         out_kind_o,
  output logic [15:0]        out_value_o,
  output logic               halted_o,
  output logic [15:0]        top_value_o,
  output logic [2:0]         error_code_o
);

  localparam int W  = smis_pkg::WORD_BITS;
  localparam int DW = W + 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int MW = $clog2(MEM_WORDS);
  localparam logic [W:0] MEM_LIM = (W + 1)'(MEM_WORDS);

  logic [W-1:0] stk [STACK_DEPTH];
  logic [W-1:0] dmem [MEM_WORDS];

  logic [4:0]    kind_q;
  logic [W-1:0]  op_q, sup_q, pc_q, s1_q, s2_q, m0_q, m1_q, top_q;
  logic [CW-1:0] n_q;
  logic          halt_q, go_q;
  logic [2:0]    err_q;
  logic [MW-1:0] clr_q;
  logic [1:0]    rkind_q;
  logic [W-1:0]  rval_q;

  logic          out_valid_q;
  logic [W-1:0]  o_pc_q, o_val_q, o_top_q;
  logic [1:0]    o_kind_q;
  logic          o_halt_q;
  logic [2:0]    o_err_q;

  logic [CW-1:0] nm1, nm2;
  logic          n_ge1, n_ge2, full;
  logic          op_oob, s1_oob, s2_oob, sub_bad, unary, take, divsub;
  logic [2:0]    err_c;
  logic [W-1:0]  ma0;

  assign nm1   = n_q - CW'(1);
  assign nm2   = n_q - CW'(2);
  assign n_ge1 = n_q != '0;
  assign n_ge2 = n_q >= CW'(2);
  assign full  = n_q >= CW'(STACK_DEPTH);

  assign op_oob  = {1'b0, op_q} >= MEM_LIM;
  assign s1_oob  = {1'b0, s1_q} >= MEM_LIM;
  assign s2_oob  = {1'b0, s2_q} >= MEM_LIM;
  assign sub_bad = |op_q[W-1:4];
  assign unary   = op_q[3:0] inside {smis_pkg::A_NOT, smis_pkg::A_NEG};
  assign divsub  = op_q[3:0] inside {smis_pkg::A_DIV, smis_pkg::A_MOD};
  assign take    = (s1_q != '0) == (kind_q == smis_pkg::K_RETZ);

  // checks, in the order the instruction set defines
  always_comb begin
    err_c = smis_pkg::E_NONE;
    case (kind_q)
      smis_pkg::K_POP:
        err_c = !n_ge1 ? smis_pkg::E_STK : op_oob ? smis_pkg::E_ADR : smis_pkg::E_NONE;
      smis_pkg::K_PUSH:
        err_c = op_oob ? smis_pkg::E_ADR : full ? smis_pkg::E_STK : smis_pkg::E_NONE;
      smis_pkg::K_STORE, smis_pkg::K_MSWAP:
        err_c = !n_ge2 ? smis_pkg::E_STK :
                (s1_oob || (kind_q == smis_pkg::K_MSWAP && s2_oob)) ? smis_pkg::E_ADR :
                smis_pkg::E_NONE;
      smis_pkg::K_LOAD:
        err_c = !n_ge1 ? smis_pkg::E_STK : s1_oob ? smis_pkg::E_ADR : smis_pkg::E_NONE;
      smis_pkg::K_PUSHS, smis_pkg::K_GETC, smis_pkg::K_CALL:
        err_c = full ? smis_pkg::E_STK : smis_pkg::E_NONE;
      smis_pkg::K_RET, smis_pkg::K_JPC, smis_pkg::K_PUTC:
        err_c = !n_ge1 ? smis_pkg::E_STK : smis_pkg::E_NONE;
      smis_pkg::K_RETZ, smis_pkg::K_RETNZ:
        err_c = (!n_ge1 || (take && !n_ge2)) ? smis_pkg::E_STK : smis_pkg::E_NONE;
      smis_pkg::K_JMP, smis_pkg::K_HALT:
        err_c = smis_pkg::E_NONE;
      smis_pkg::K_WRITE, smis_pkg::K_READ:
        err_c = op_oob ? smis_pkg::E_ADR : smis_pkg::E_NONE;
      smis_pkg::K_RND:
        err_c = (op_q == W'(1)) ? smis_pkg::E_DIV : full ? smis_pkg::E_STK : smis_pkg::E_NONE;
      smis_pkg::K_DUP:
        err_c = (!n_ge1 || full) ? smis_pkg::E_STK : smis_pkg::E_NONE;
      smis_pkg::K_ALU:
        err_c = sub_bad ? smis_pkg::E_ALU :
                (unary ? !n_ge1 : !n_ge2) ? smis_pkg::E_STK :
                (divsub && s1_q == '0) ? smis_pkg::E_DIV : smis_pkg::E_NONE;
      default:
        err_c = smis_pkg::E_OPC;
    endcase
    if (halt_q) err_c = smis_pkg::E_NONE;
  end

  assign ma0 = (kind_q inside {smis_pkg::K_PUSH, smis_pkg::K_WRITE}) ? op_q : s1_q;

  // divider operands: rnd is unsigned by |operand-1|, alu div/mod by magnitudes
  logic [DW-1:0] rnd_dm, rnd_d, v_ext, u_ext, v_abs, u_abs, div_a, div_d, div_q, div_r;
  logic [DW-1:0] q_sgn, r_sgn;
  logic          div_done, is_rnd;

  assign is_rnd = kind_q == smis_pkg::K_RND;
  assign rnd_dm = {op_q[W-1], op_q} - DW'(1);
  assign rnd_d  = rnd_dm[DW-1] ? -rnd_dm : rnd_dm;
  assign v_ext  = {s2_q[W-1], s2_q};
  assign u_ext  = {s1_q[W-1], s1_q};
  assign v_abs  = s2_q[W-1] ? -v_ext : v_ext;
  assign u_abs  = s1_q[W-1] ? -u_ext : u_ext;
  assign div_a  = is_rnd ? {1'b0, sup_q} : v_abs;
  assign div_d  = is_rnd ? rnd_d : u_abs;

  smis_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .a_i     (div_a),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q),
    .r_o     (div_r)
  );

  assign q_sgn = (s2_q[W-1] ^ s1_q[W-1]) ? -div_q : div_q;
  assign r_sgn = s2_q[W-1] ? -div_r : div_r;

  // alu
  logic signed [W-1:0]   u_s, v_s;
  logic signed [2*W-1:0] prod;
  logic [W-1:0]          alu_r;

  assign u_s  = s1_q;
  assign v_s  = s2_q;
  assign prod = v_s * u_s;

  always_comb begin
    alu_r = '0;
    case (op_q[3:0])
      smis_pkg::A_EQ:  alu_r = W'(v_s == u_s);
      smis_pkg::A_NE:  alu_r = W'(v_s != u_s);
      smis_pkg::A_GT:  alu_r = W'(v_s > u_s);
      smis_pkg::A_GE:  alu_r = W'(v_s >= u_s);
      smis_pkg::A_LT:  alu_r = W'(v_s < u_s);
      smis_pkg::A_LE:  alu_r = W'(v_s <= u_s);
      smis_pkg::A_AND: alu_r = s2_q & s1_q;
      smis_pkg::A_OR:  alu_r = s2_q | s1_q;
      smis_pkg::A_XOR: alu_r = s2_q ^ s1_q;
      smis_pkg::A_NOT: alu_r = ~s1_q;
      smis_pkg::A_NEG: alu_r = -s1_q;
      smis_pkg::A_ADD: alu_r = s2_q + s1_q;
      smis_pkg::A_SUB: alu_r = s2_q - s1_q;
      smis_pkg::A_MUL: alu_r = prod[W-1:0];
      smis_pkg::A_DIV: alu_r = q_sgn[W-1:0];
      smis_pkg::A_MOD: alu_r = r_sgn[W-1:0];
      default:         alu_r = '0;
    endcase
  end

  // writeback decode
  logic [W-1:0]  pc_inc, pc_rel;
  logic          sw_en, dw_en;
  logic [SW-1:0] sw_addr;
  logic [W-1:0]  sw_data, dw_addr, dw_data, pc_d, oval;
  logic [CW-1:0] n_d;
  logic [1:0]    okind;

  assign pc_inc = pc_q + W'(2);
  assign pc_rel = pc_q + {op_q[W-2:0], 1'b0} + W'(2);

  always_comb begin
    sw_en   = 1'b0;
    sw_addr = n_q[SW-1:0];
    sw_data = '0;
    dw_en   = 1'b0;
    dw_addr = op_q;
    dw_data = s1_q;
    n_d     = n_q;
    pc_d    = pc_inc;
    okind   = smis_pkg::O_NONE;
    oval    = '0;
    case (kind_q)
      smis_pkg::K_POP: begin
        dw_en = 1'b1;
        n_d   = nm1;
      end
      smis_pkg::K_PUSH: begin
        sw_en   = 1'b1;
        sw_data = m0_q;
        n_d     = n_q + CW'(1);
      end
      smis_pkg::K_STORE: begin
        dw_en   = 1'b1;
        dw_addr = s1_q;
        dw_data = s2_q;
        n_d     = nm2;
      end
      smis_pkg::K_LOAD: begin
        sw_en   = 1'b1;
        sw_addr = nm1[SW-1:0];
        sw_data = m0_q;
      end
      smis_pkg::K_PUSHS, smis_pkg::K_GETC, smis_pkg::K_CALL, smis_pkg::K_RND,
      smis_pkg::K_DUP: begin
        sw_en = 1'b1;
        n_d   = n_q + CW'(1);
        case (kind_q)
          smis_pkg::K_PUSHS: sw_data = op_q;
          smis_pkg::K_GETC:  sw_data = sup_q;
          smis_pkg::K_CALL: begin
            sw_data = pc_q;
            pc_d    = pc_rel;
          end
          smis_pkg::K_RND:   sw_data = div_r[W-1:0];
          default:           sw_data = s1_q;
        endcase
      end
      smis_pkg::K_RET: begin
        n_d  = nm1;
        pc_d = s1_q + W'(2);
      end
      smis_pkg::K_RETZ, smis_pkg::K_RETNZ: begin
        if (take) begin
          n_d  = nm2;
          pc_d = s2_q + W'(2);
        end else begin
          n_d = nm1;
        end
      end
      smis_pkg::K_JMP: pc_d = pc_rel;
      smis_pkg::K_JPC: begin
        n_d = nm1;
        if (s1_q != '0) pc_d = pc_rel;
      end
      smis_pkg::K_WRITE: begin
        okind = smis_pkg::O_NUM;
        oval  = m0_q;
      end
      smis_pkg::K_READ: begin
        dw_en   = 1'b1;
        dw_data = sup_q;
      end
      smis_pkg::K_PUTC: begin
        n_d   = nm1;
        okind = smis_pkg::O_CHR;
        oval  = {{(W-8){1'b0}}, s1_q[7:0]};
      end
      smis_pkg::K_MSWAP: begin
        dw_en   = 1'b1;
        dw_addr = s1_q;
        dw_data = m1_q;
        n_d     = nm2;
      end
      smis_pkg::K_ALU: begin
        sw_en   = 1'b1;
        sw_data = alu_r;
        if (unary) begin
          sw_addr = nm1[SW-1:0];
        end else begin
          sw_addr = nm2[SW-1:0];
          n_d     = nm1;
        end
      end
      smis_pkg::K_HALT: pc_d = pc_q;
      default: pc_d = pc_q;
    endcase
  end

  // memory write port: clearing pass, writeback, second half of mswap
  logic          dm_we;
  logic [MW-1:0] dm_wa;
  logic [W-1:0]  dm_wd;

  always_comb begin
    dm_we = 1'b0;
    dm_wa = dw_addr[MW-1:0];
    dm_wd = dw_data;
    if (cmd_i.clr) begin
      dm_we = 1'b1;
      dm_wa = clr_q;
      dm_wd = '0;
    end else if (cmd_i.wb) begin
      dm_we = go_q && dw_en;
    end else if (cmd_i.wb2) begin
      dm_we = 1'b1;
      dm_wa = s2_q[MW-1:0];
      dm_wd = m0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dmem[dm_wa] <= dm_wd;
    if (cmd_i.ex1) begin
      m0_q <= dmem[ma0[MW-1:0]];
      m1_q <= dmem[s2_q[MW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb && go_q && sw_en) stk[sw_addr] <= sw_data;
    if (cmd_i.rd) begin
      s1_q <= stk[nm1[SW-1:0]];
      s2_q <= stk[nm2[SW-1:0]];
    end
    if (cmd_i.top) top_q <= stk[nm1[SW-1:0]];
  end

  // item payload and per-item results
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= instr_kind_i;
      op_q   <= operand_i;
      sup_q  <= supplied_value_i;
    end
    if (cmd_i.ex1) err_q <= err_c;
    if (cmd_i.wb) begin
      rkind_q <= go_q ? okind : smis_pkg::O_NONE;
      rval_q  <= go_q ? oval : '0;
    end
    if (cmd_i.load_out) begin
      o_pc_q   <= pc_q;
      o_kind_q <= rkind_q;
      o_val_q  <= rval_q;
      o_halt_q <= halt_q;
      o_top_q  <= (n_q == '0) ? '0 : top_q;
      o_err_q  <= err_q;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      n_q         <= '0;
      halt_q      <= 1'b0;
      go_q        <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + MW'(1);
      if (cmd_i.ex1) go_q <= !halt_q && (err_c == smis_pkg::E_NONE);
      if (cmd_i.wb) begin
        if (go_q) begin
          pc_q <= pc_d;
          n_q  <= n_d;
        end
        if ((err_q != smis_pkg::E_NONE) || (go_q && kind_q == smis_pkg::K_HALT)) begin
          halt_q <= 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_done = clr_q == MW'(MEM_WORDS - 1);
  assign sts_o.need_div = go_q && (is_rnd || (kind_q == smis_pkg::K_ALU && divsub));
  assign sts_o.div_done = div_done;
  assign sts_o.need_wb2 = go_q && (kind_q == smis_pkg::K_MSWAP);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign next_pc_o    = o_pc_q;
  assign out_kind_o   = o_kind_q;
  assign out_value_o  = o_val_q;
  assign halted_o     = o_halt_q;
  assign top_value_o  = o_top_q;
  assign error_code_o = o_err_q;

endmodule

// File: rtl/stack_machine_instruction_step_core.sv
// items: one item is in flight at a time; a new item is accepted only once the last
// result has been loaded into the output register, after the stack and data memory
// sequence and, for div, mod and rnd, the 17-step divider
// reset: pc, stack count and halt flag clear; data memory is then zeroed by a clearing
// pass over all MEM_WORDS words during which no item is accepted
// ----------------------------------------------------------------------------
// stack_machine_instruction_step_core
// Executes one instruction item of a 16-bit stack machine per accepted item.
// ----------------------------------------------------------------------------
module stack_machine_instruction_step_core #(
  parameter int MEM_WORDS   = smis_pkg::MEM_WORDS_DEF,
  parameter int STACK_DEPTH = smis_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smis_in_if.sink   inst_i,
  smis_out_if.source res_o
);

  smis_pkg::cmd_t cmd;
  smis_pkg::sts_t sts;

  smis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (inst_i.valid),
    .in_ready_o (inst_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smis_dp #(
    .MEM_WORDS   (MEM_WORDS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .instr_kind_i     (inst_i.instr_kind),
    .operand_i        (inst_i.operand),
    .supplied_value_i (inst_i.supplied_value),
    .out_valid_o      (res_o.valid),
    .out_ready_i      (res_o.ready),
    .next_pc_o        (res_o.next_pc),
    .out_kind_o       (res_o.out_kind),
    .out_value_o      (res_o.out_value),
    .halted_o         (res_o.halted),
    .top_value_o      (res_o.top_value),
    .error_code_o     (res_o.error_code)
  );

`ifndef SYNTHESIS
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.error_code != smis_pkg::E_NONE |-> res_o.halted)
    else $error("error reported without halt");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inst_i.valid && inst_i.ready |=> !inst_i.ready)
    else $error("item accepted while another is in flight");

  a_out_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.out_kind != smis_pkg::O_NONE |-> res_o.error_code == smis_pkg::E_NONE)
    else $error("output produced on a faulting item");
`endif

endmodule

// File: verif/tb_smis_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smis_if
// Testbench-side copies are not needed: the channel interfaces come from the
// RTL. This file holds the item types that the driver and monitor share.
// ----------------------------------------------------------------------------
package tb_smis_pkg;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] operand;
    logic [15:0] supplied;
  } instr_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [1:0]  out_kind;
    logic [15:0] out_value;
    logic        halted;
    logic [15:0] top_value;
    logic [2:0]  error_code;
  } step_result_t;

endpackage

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives instruction items into the stack machine step core and checks every
// result against an in-bench machine model, under bursty input and stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int MEMW = smis_pkg::MEM_WORDS_DEF;
  localparam int DEPTH = smis_pkg::STACK_DEPTH_DEF;
  localparam int WATCH_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  smis_in_if  inst_if ();
  smis_out_if res_if ();

  stack_machine_instruction_step_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .inst_i(inst_if.sink),
    .res_o (res_if.source)
  );

  // machine model state
  logic [15:0] m_pc;
  logic [15:0] m_stack [DEPTH];
  int          m_count;
  logic [15:0] m_mem [MEMW];
  logic        m_halt;

  tb_smis_pkg::instr_item_t  pending_q [$];
  tb_smis_pkg::step_result_t expected_q [$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_halts = 0;
  bit hold_off = 0;

  function automatic logic [15:0] jump_target(logic [15:0] pc, logic [15:0] off);
    return pc + 16'(2 * (int'($signed(off)) + 1));
  endfunction

  task automatic machine_step(input tb_smis_pkg::instr_item_t it,
                              output tb_smis_pkg::step_result_t r);
    logic [15:0] next, oval, a, b, t, u16, v16, res16;
    logic [1:0]  okind;
    logic [2:0]  err;
    int n, d;
    int signed u, v;
    logic unary, take;
    next = m_pc + 16'd2;
    n = m_count;
    err = smis_pkg::E_NONE;
    okind = smis_pkg::O_NONE;
    oval = '0;
    if (!m_halt) begin
      case (it.kind)
        smis_pkg::K_POP: begin
          if (n < 1) err = smis_pkg::E_STK;
          else if (it.operand >= MEMW) err = smis_pkg::E_ADR;
          else begin
            n--;
            m_mem[it.operand] = m_stack[n];
          end
        end
        smis_pkg::K_PUSH: begin
          if (it.operand >= MEMW) err = smis_pkg::E_ADR;
          else if (n >= DEPTH) err = smis_pkg::E_STK;
          else begin
            m_stack[n] = m_mem[it.operand];
            n++;
          end
        end
        smis_pkg::K_STORE: begin
          if (n < 2) err = smis_pkg::E_STK;
          else if (m_stack[n-1] >= MEMW) err = smis_pkg::E_ADR;
          else begin
            m_mem[m_stack[n-1]] = m_stack[n-2];
            n -= 2;
          end
        end
        smis_pkg::K_LOAD: begin
          if (n < 1) err = smis_pkg::E_STK;
          else if (m_stack[n-1] >= MEMW) err = smis_pkg::E_ADR;
          else m_stack[n-1] = m_mem[m_stack[n-1]];
        end
        smis_pkg::K_PUSHS, smis_pkg::K_GETC: begin
          if (n >= DEPTH) err = smis_pkg::E_STK;
          else begin
            m_stack[n] = (it.kind == smis_pkg::K_PUSHS) ? it.operand : it.supplied;
            n++;
          end
        end
        smis_pkg::K_CALL: begin
          if (n >= DEPTH) err = smis_pkg::E_STK;
          else begin
            m_stack[n] = m_pc;
            n++;
            next = jump_target(m_pc, it.operand);
          end
        end
        smis_pkg::K_RET: begin
          if (n < 1) err = smis_pkg::E_STK;
          else begin
            n--;
            next = m_stack[n] + 16'd2;
          end
        end
        smis_pkg::K_RETZ, smis_pkg::K_RETNZ: begin
          if (n < 1) err = smis_pkg::E_STK;
          else begin
            take = (m_stack[n-1] != 0) == (it.kind == smis_pkg::K_RETZ);
            if (!take) n--;
            else if (n < 2) err = smis_pkg::E_STK;
            else begin
              next = m_stack[n-2] + 16'd2;
              n -= 2;
            end
          end
        end
        smis_pkg::K_JMP: next = jump_target(m_pc, it.operand);
        smis_pkg::K_JPC: begin
          if (n < 1) err = smis_pkg::E_STK;
          else begin
            n--;
            if (m_stack[n] != 0) next = jump_target(m_pc, it.operand);
          end
        end
        smis_pkg::K_WRITE: begin
          if (it.operand >= MEMW) err = smis_pkg::E_ADR;
          else begin
            okind = smis_pkg::O_NUM;
            oval = m_mem[it.operand];
          end
        end
        smis_pkg::K_READ: begin
          if (it.operand >= MEMW) err = smis_pkg::E_ADR;
          else m_mem[it.operand] = it.supplied;
        end
        smis_pkg::K_PUTC: begin
          if (n < 1) err = smis_pkg::E_STK;
          else begin
            n--;
            okind = smis_pkg::O_CHR;
            oval = {8'd0, m_stack[n][7:0]};
          end
        end
        smis_pkg::K_RND: begin
          d = int'($signed(it.operand)) - 1;
          if (d < 0) d = -d;
          if (d == 0) err = smis_pkg::E_DIV;
          else if (n >= DEPTH) err = smis_pkg::E_STK;
          else begin
            m_stack[n] = 16'(int'(it.supplied) % d);
            n++;
          end
        end
        smis_pkg::K_DUP: begin
          if (n < 1 || n >= DEPTH) err = smis_pkg::E_STK;
          else begin
            m_stack[n] = m_stack[n-1];
            n++;
          end
        end
        smis_pkg::K_MSWAP: begin
          if (n < 2) err = smis_pkg::E_STK;
          else begin
            a = m_stack[n-1];
            b = m_stack[n-2];
            if (a >= MEMW || b >= MEMW) err = smis_pkg::E_ADR;
            else begin
              t = m_mem[a];
              m_mem[a] = m_mem[b];
              m_mem[b] = t;
              n -= 2;
            end
          end
        end
        smis_pkg::K_ALU: begin
          unary = it.operand inside {16'(smis_pkg::A_NOT), 16'(smis_pkg::A_NEG)};
          if (it.operand > 16'hf) err = smis_pkg::E_ALU;
          else if (n < (unary ? 1 : 2)) err = smis_pkg::E_STK;
          else begin
            u16 = m_stack[n-1];
            v16 = unary ? 16'd0 : m_stack[n-2];
            u = int'($signed(u16));
            v = int'($signed(v16));
            res16 = '0;
            case (it.operand[3:0])
              smis_pkg::A_EQ:  res16 = 16'(v == u);
              smis_pkg::A_NE:  res16 = 16'(v != u);
              smis_pkg::A_GT:  res16 = 16'(v > u);
              smis_pkg::A_GE:  res16 = 16'(v >= u);
              smis_pkg::A_LT:  res16 = 16'(v < u);
              smis_pkg::A_LE:  res16 = 16'(v <= u);
              smis_pkg::A_AND: res16 = v16 & u16;
              smis_pkg::A_OR:  res16 = v16 | u16;
              smis_pkg::A_XOR: res16 = v16 ^ u16;
              smis_pkg::A_NOT: res16 = ~u16;
              smis_pkg::A_NEG: res16 = 16'(-u);
              smis_pkg::A_ADD: res16 = 16'(v + u);
              smis_pkg::A_SUB: res16 = 16'(v - u);
              smis_pkg::A_MUL: res16 = 16'(v * u);
              default: begin
                if (u == 0) err = smis_pkg::E_DIV;
                else if (it.operand[3:0] == smis_pkg::A_DIV) res16 = 16'(v / u);
                else res16 = 16'(v % u);
              end
            endcase
            if (err == smis_pkg::E_NONE) begin
              n -= unary ? 1 : 2;
              m_stack[n] = res16;
              n++;
            end
          end
        end
        smis_pkg::K_HALT: begin
          m_halt = 1'b1;
          next = m_pc;
        end
        default: err = smis_pkg::E_OPC;
      endcase
      if (err != smis_pkg::E_NONE) begin
        m_halt = 1'b1;
        next = m_pc;
        okind = smis_pkg::O_NONE;
        oval = '0;
      end else begin
        m_count = n;
        m_pc = next;
      end
    end else begin
      next = m_pc;
    end
    r.next_pc = next;
    r.out_kind = okind;
    r.out_value = oval;
    r.halted = m_halt;
    r.top_value = (m_count > 0) ? m_stack[m_count-1] : 16'd0;
    r.error_code = err;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("tb: mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
  endtask

  // ---- sender: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    tb_smis_pkg::step_result_t r;
    if (!rst_ni) begin
      inst_if.valid <= 1'b0;
      inst_if.instr_kind <= '0;
      inst_if.operand <= '0;
      inst_if.supplied_value <= '0;
    end else begin
      if (inst_if.valid && inst_if.ready) begin
        machine_step(pending_q.pop_front(), r);
        expected_q.push_back(r);
        n_sent++;
      end
      if (!inst_if.valid || inst_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          inst_if.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          inst_if.valid <= 1'b1;
          inst_if.instr_kind <= pending_q[0].kind;
          inst_if.operand <= pending_q[0].operand;
          inst_if.supplied_value <= pending_q[0].supplied;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(12);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
          end
        end else begin
          inst_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver with its own stall pattern
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    tb_smis_pkg::step_result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result next_pc", res_if.next_pc, 16'd0);
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (res_if.halted) n_halts++;
          if (res_if.next_pc !== want.next_pc)
            report_mismatch("next_pc", res_if.next_pc, want.next_pc);
          if (res_if.out_kind !== want.out_kind)
            report_mismatch("out_kind", 16'(res_if.out_kind), 16'(want.out_kind));
          if (res_if.out_value !== want.out_value)
            report_mismatch("out_value", res_if.out_value, want.out_value);
          if (res_if.halted !== want.halted)
            report_mismatch("halted", 16'(res_if.halted), 16'(want.halted));
          if (res_if.top_value !== want.top_value)
            report_mismatch("top_value", res_if.top_value, want.top_value);
          if (res_if.error_code !== want.error_code)
            report_mismatch("error_code", 16'(res_if.error_code), 16'(want.error_code));
        end
      end
      stall_phase = (stall_phase + 1) % 37;
      if (hold_off) res_if.ready <= 1'b0;
      else if (stall_phase < 12) res_if.ready <= 1'b1;
      else res_if.ready <= ($urandom_range(2) != 0);
    end
  end

  // ---- long hold-off while the sender keeps offering
  initial begin
    wait (rst_ni);
    wait (n_sent > 40);
    hold_off = 1;
    repeat (400) @(posedge clk_i);
    hold_off = 0;
  end

  // ---- watchdog: cycles with nothing accepted
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((inst_if.valid && inst_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("tb: stalled after %0d items sent and %0d results checked", n_sent, n_checked);
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic tb_smis_pkg::instr_item_t mk(logic [4:0] k, logic [15:0] op,
                                                  logic [15:0] sv);
    tb_smis_pkg::instr_item_t it;
    it.kind = k;
    it.operand = op;
    it.supplied = sv;
    return it;
  endfunction

  function automatic logic [15:0] small_addr();
    return 16'($urandom_range(15));
  endfunction

  // well-formed-ish program segment: values pushed then consumed
  task automatic add_random_item();
    int sel;
    logic [15:0] op, sv;
    sel = $urandom_range(99);
    op = $urandom();
    sv = $urandom();
    if (sel < 20)
      pending_q.push_back(mk(smis_pkg::K_PUSHS, ($urandom_range(1) ? small_addr() : op), sv));
    else if (sel < 28) pending_q.push_back(mk(smis_pkg::K_ALU, 16'($urandom_range(15)), sv));
    else if (sel < 30) pending_q.push_back(mk(smis_pkg::K_ALU, op, sv));
    else if (sel < 34) pending_q.push_back(mk(smis_pkg::K_POP, small_addr(), sv));
    else if (sel < 38) pending_q.push_back(mk(smis_pkg::K_PUSH, small_addr(), sv));
    else if (sel < 41) pending_q.push_back(mk(smis_pkg::K_STORE, op, sv));
    else if (sel < 44) pending_q.push_back(mk(smis_pkg::K_LOAD, op, sv));
    else if (sel < 47) pending_q.push_back(mk(smis_pkg::K_CALL, op, sv));
    else if (sel < 50) pending_q.push_back(mk(smis_pkg::K_RET, op, sv));
    else if (sel < 53) pending_q.push_back(mk(smis_pkg::K_RETZ, op, sv));
    else if (sel < 56) pending_q.push_back(mk(smis_pkg::K_RETNZ, op, sv));
    else if (sel < 59) pending_q.push_back(mk(smis_pkg::K_JMP, op, sv));
    else if (sel < 62) pending_q.push_back(mk(smis_pkg::K_JPC, op, sv));
    else if (sel < 65) pending_q.push_back(mk(smis_pkg::K_WRITE, small_addr(), sv));
    else if (sel < 68) pending_q.push_back(mk(smis_pkg::K_READ, small_addr(), sv));
    else if (sel < 72) pending_q.push_back(mk(smis_pkg::K_GETC, op, sv));
    else if (sel < 75) pending_q.push_back(mk(smis_pkg::K_PUTC, op, sv));
    else if (sel < 80) pending_q.push_back(mk(smis_pkg::K_RND, op, sv));
    else if (sel < 86) pending_q.push_back(mk(smis_pkg::K_DUP, op, sv));
    else if (sel < 89) pending_q.push_back(mk(smis_pkg::K_MSWAP, op, sv));
    else if (sel < 92) pending_q.push_back(mk(5'($urandom_range(31)), op, sv));
    else if (sel < 96) pending_q.push_back(mk(smis_pkg::K_WRITE, op, sv));
    else pending_q.push_back(mk(smis_pkg::K_READ, op, sv));
  endtask

  initial begin
    int seg;
    inst_if.valid = 1'b0;
    inst_if.instr_kind = '0;
    inst_if.operand = '0;
    inst_if.supplied_value = '0;
    res_if.ready = 1'b0;
    m_pc = '0;
    m_count = 0;
    m_halt = 1'b0;
    foreach (m_mem[k]) m_mem[k] = '0;
    foreach (m_stack[k]) m_stack[k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and every opcode but store, load and halt
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'h8000, 16'hffff));
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'hffff, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_ALU, 16'(smis_pkg::A_DIV), 16'h0));
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'h7fff, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_POP, 16'd4095, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_WRITE, 16'd4095, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_READ, 16'd3, 16'h8000));
    pending_q.push_back(mk(smis_pkg::K_PUSH, 16'd3, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_GETC, 16'h0, 16'h7fff));
    pending_q.push_back(mk(smis_pkg::K_PUTC, 16'h0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_RND, 16'h8000, 16'hffff));
    pending_q.push_back(mk(smis_pkg::K_RND, 16'h0, 16'h1234));
    pending_q.push_back(mk(smis_pkg::K_DUP, 16'h0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_CALL, 16'd5, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_RET, 16'h0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'd0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_RETZ, 16'h0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'd0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_RETNZ, 16'h0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_JMP, 16'h8000, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'd1, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_JPC, 16'h7fff, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'd2, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'd3, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_MSWAP, 16'h0, 16'h0));

    // random segments, each starting from reset-free ongoing state; the
    // machine halts on faults, so most segments use few faulty items
    for (seg = 0; seg < 525; seg++) add_random_item();
    // error cases at the very end: divide by zero, bad opcode, halt stays
    pending_q.push_back(mk(smis_pkg::K_RND, 16'd1, 16'h0));
    pending_q.push_back(mk(5'd31, 16'h0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_HALT, 16'h0, 16'h0));
    pending_q.push_back(mk(smis_pkg::K_PUSHS, 16'hffff, 16'h0));

    wait (pending_q.size() == 0 && !inst_if.valid);
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("tb: %0d instruction items sent, %0d results checked, %0d halted",
             n_sent, n_checked, n_halts);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/smis_pkg.sv
rtl/smis_if.sv
rtl/smis_div.sv
rtl/smis_ctrl.sv
rtl/smis_dp.sv
rtl/stack_machine_instruction_step_core.sv
verif/tb_smis_if.sv
verif/tb.sv
